// File: sv/ubxd_pkg.sv
`default_nettype none

package ubxd_pkg;

    // Frame framing and message identification constants.
    localparam logic [7:0]  SYNC_FIRST         = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND        = 8'h62;
    localparam logic [7:0]  NAV_CLASS          = 8'h01;
    localparam logic [7:0]  PVT_ID             = 8'h07;
    localparam logic [7:0]  RELPOS_ID          = 8'h3C;
    localparam logic [15:0] DEFAULT_MAX_LENGTH = 16'd1024;

    // Widths of the stream payloads.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 4;

    // Kind of event carried by one output transfer.
    typedef enum logic [1:0] {
        EV_PAYLOAD    = 2'd0,
        EV_FRAME_GOOD = 2'd1,
        EV_CSUM_ERROR = 2'd2,
        EV_LEN_REJECT = 2'd3
    } event_kind_t;

    // Message tag derived from class and id.
    typedef enum logic [1:0] {
        MSG_OTHER  = 2'd0,
        MSG_PVT    = 2'd1,
        MSG_RELPOS = 2'd2
    } msg_kind_t;

    // One result item as handed from the parser to the output register.
    typedef struct packed {
        event_kind_t event_kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] frame_length;
        msg_kind_t   msg_kind;
    } result_t;

endpackage

`default_nettype wire

// File: sv/ubxd_in_stage.sv
`default_nettype none

module ubxd_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ubxd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  wire logic                           advance,
    output logic                                byte_valid,
    output logic [7:0]                          rx_byte
);
    import ubxd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    // The stage can take a new byte when empty or when its byte moves on.
    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

    // Input register for one received byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata[7:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/ubxd_parse.sv
`default_nettype none

module ubxd_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    output logic                   res_valid,
    output ubxd_pkg::result_t      res
);
    import ubxd_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  rx_sum_a_reg, rx_sum_a_next;
    logic [15:0] max_length_reg;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] length_hi;
    logic [16:0] seen_plus;
    msg_kind_t   kind;

    // Running Fletcher sums with the current byte folded in.
    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign length_hi = {rx_byte, length_reg[7:0]};
    assign seen_plus = {1'b0, seen_reg} + 17'd1;

    // Message tag from the stored class and id.
    always_comb begin
        if (class_reg == NAV_CLASS && id_reg == PVT_ID) begin
            kind = MSG_PVT;
        end else if (class_reg == NAV_CLASS && id_reg == RELPOS_ID) begin
            kind = MSG_RELPOS;
        end else begin
            kind = MSG_OTHER;
        end
    end

    // Frame state machine: next state and the result of this byte.
    always_comb begin
        phase_next    = phase_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        class_next    = class_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        seen_next     = seen_reg;
        rx_sum_a_next = rx_sum_a_reg;
        res_valid     = 1'b0;
        res.event_kind   = EV_PAYLOAD;
        res.data_byte    = 8'd0;
        res.byte_offset  = 16'd0;
        res.msg_class    = class_reg;
        res.msg_id       = id_reg;
        res.frame_length = length_reg;
        res.msg_kind     = kind;
        unique case (phase_reg)
            PH_SYNC2: begin
                if (rx_byte == SYNC_SECOND) begin
                    phase_next = PH_CLASS;
                end else if (rx_byte == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                class_next = rx_byte;
                phase_next = PH_ID;
            end
            PH_ID: begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                id_next    = rx_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                length_next = {8'd0, rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                sum_a_next       = add_a;
                sum_b_next       = add_b;
                length_next      = length_hi;
                seen_next        = 16'd0;
                res.frame_length = length_hi;
                if (length_hi > max_length_reg) begin
                    phase_next     = PH_SYNC1;
                    res_valid      = 1'b1;
                    res.event_kind = EV_LEN_REJECT;
                end else if (length_hi == 16'd0) begin
                    phase_next = PH_CK_A;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                sum_a_next      = add_a;
                sum_b_next      = add_b;
                res_valid       = 1'b1;
                res.event_kind  = EV_PAYLOAD;
                res.data_byte   = rx_byte;
                res.byte_offset = seen_reg;
                if (seen_plus >= {1'b0, length_reg}) begin
                    phase_next = PH_CK_A;
                end else begin
                    seen_next = seen_plus[15:0];
                end
            end
            PH_CK_A: begin
                rx_sum_a_next = rx_byte;
                phase_next    = PH_CK_B;
            end
            PH_CK_B: begin
                phase_next = PH_SYNC1;
                res_valid  = 1'b1;
                if (rx_sum_a_reg == sum_a_reg && rx_byte == sum_b_reg) begin
                    res.event_kind = EV_FRAME_GOOD;
                end else begin
                    res.event_kind = EV_CSUM_ERROR;
                end
            end
            default: begin
                // Hunting the first sync byte; unused codes land here too.
                phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    // State registers advance on each byte that leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC1;
            sum_a_reg    <= 8'd0;
            sum_b_reg    <= 8'd0;
            class_reg    <= 8'd0;
            id_reg       <= 8'd0;
            length_reg   <= 16'd0;
            seen_reg     <= 16'd0;
            rx_sum_a_reg <= 8'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            class_reg    <= class_next;
            id_reg       <= id_next;
            length_reg   <= length_next;
            seen_reg     <= seen_next;
            rx_sum_a_reg <= rx_sum_a_next;
        end
    end

    // Maximum payload length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= DEFAULT_MAX_LENGTH;
        end else if (cfg_we) begin
            max_length_reg <= cfg_wdata;
        end
    end

    // A payload offset always lies inside the announced length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.event_kind == EV_PAYLOAD |-> res.byte_offset < res.frame_length)
        else $error("payload offset beyond frame length");

    // A rejected length really exceeds the configured maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.event_kind == EV_LEN_REJECT |-> res.frame_length > max_length_reg)
        else $error("length rejected without exceeding the maximum");

    // After a frame ends the parser is hunting again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && res.event_kind != EV_PAYLOAD |=> phase_reg == PH_SYNC1)
        else $error("parser did not return to hunting after frame end");

endmodule

`default_nettype wire

// File: sv/ubxd_out_stage.sv
`default_nettype none

module ubxd_out_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire ubxd_pkg::result_t              res,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] data_byte, [23:8] byte_offset, [31:24] msg_class, [39:32] msg_id,
    // [55:40] frame_length
    output logic [ubxd_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] event_kind, [3:2] msg_kind
    output logic [ubxd_pkg::M_TUSER_W-1:0]      m_tuser
);
    import ubxd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // The register can be refilled when empty or while its transfer completes.
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.frame_length, res_reg.msg_id, res_reg.msg_class,
                       res_reg.byte_offset, res_reg.data_byte};
    assign m_tuser  = {res_reg.msg_kind, res_reg.event_kind};

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    // A result is only loaded when the register has room for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result loaded over an untaken result");

    // A load always leaves a valid result behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid)
        else $error("loaded result not presented");

    // A held result is not overwritten while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// File: sv/ubx_frame_deframer_core.sv
// Frame deframer for a binary receiver protocol with an 8-bit Fletcher checksum.
// The s_ channel takes one received serial byte per transfer in s_tdata[7:0].
// The m_ channel gives at most one event per byte: a payload byte with its
// offset, a good frame, a checksum error or a rejected length. m_tuser holds
// the event kind and the message tag; m_tdata holds the byte, its offset, the
// class, id and announced length of the current frame.
// cfg_we with cfg_wdata writes the largest accepted payload length (reset 1024);
// write it only while no bytes are in flight.
// An event appears on m_ the cycle after its byte leaves the input register,
// which captured the byte at its transfer on s_.
// One byte per cycle while the output register has room, handled by the frame
// state machine between the input register and the output register.
// When the receiver stalls, the output register holds its event and the input
// register holds one more byte; then s_tready drops.
// Synchronous active-low reset empties both registers and restarts the hunt for
// the first sync byte.
`default_nettype none

module ubx_frame_deframer_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [15:0]                    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ubxd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] data_byte, [23:8] byte_offset, [31:24] msg_class, [39:32] msg_id,
    // [55:40] frame_length
    output logic [ubxd_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] event_kind, [3:2] msg_kind
    output logic [ubxd_pkg::M_TUSER_W-1:0]      m_tuser
);
    import ubxd_pkg::*;

    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // A byte moves through the parser when the output register has room.
    assign advance = byte_valid && out_free;

    ubxd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    ubxd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    ubxd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: tb/sv/ubx_frame_deframer_core_test.sv
`default_nettype none

module ubx_frame_deframer_core_test;

    import ubxd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_AT = 60;
    localparam int HOLD_OFF_CYCLES = 400;

    // Parser position while walking through a frame.
    typedef enum logic [3:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        GET_CLASS,
        GET_ID,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_PAYLOAD,
        GET_CK_A,
        GET_CK_B
    } parse_phase_t;

    // Ways a generated frame may be damaged.
    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_BAD_CK_A,
        FLAW_BAD_CK_B,
        FLAW_TRUNCATED
    } frame_flaw_t;

    // Receiver pacing styles.
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_COIN,
        PACE_PERIODIC,
        PACE_SPARSE
    } rx_pace_t;

    // Tracks the frame parser byte by byte and holds the events it must produce.
    class deframe_tracker;
        logic [15:0]  max_length;
        parse_phase_t phase;
        logic [7:0]   sum_a;
        logic [7:0]   sum_b;
        logic [7:0]   got_class;
        logic [7:0]   got_id;
        logic [15:0]  frame_len;
        logic [15:0]  bytes_seen;
        logic [7:0]   rx_sum_a;
        result_t      pending_events[$];
        int           errors;

        function new();
            max_length = DEFAULT_MAX_LENGTH;
            phase = HUNT_SYNC1;
            sum_a = '0;
            sum_b = '0;
            got_class = '0;
            got_id = '0;
            frame_len = '0;
            bytes_seen = '0;
            rx_sum_a = '0;
            errors = 0;
        endfunction

        // Fletcher sums wrap at eight bits by their width.
        function void fold(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void push_event(event_kind_t ev, logic [7:0] data, logic [15:0] off);
            result_t r;
            r.event_kind = ev;
            r.data_byte = data;
            r.byte_offset = off;
            r.msg_class = got_class;
            r.msg_id = got_id;
            r.frame_length = frame_len;
            if (got_class == NAV_CLASS && got_id == PVT_ID) begin
                r.msg_kind = MSG_PVT;
            end else if (got_class == NAV_CLASS && got_id == RELPOS_ID) begin
                r.msg_kind = MSG_RELPOS;
            end else begin
                r.msg_kind = MSG_OTHER;
            end
            pending_events = {pending_events, r};
        endfunction

        // Advance the parser by one received byte.
        function void note_rx_byte(logic [7:0] b);
            logic [15:0] off;
            case (phase)
                HUNT_SYNC2: begin
                    if (b == SYNC_SECOND) begin
                        phase = GET_CLASS;
                    end else if (b == SYNC_FIRST) begin
                        phase = HUNT_SYNC2;
                    end else begin
                        phase = HUNT_SYNC1;
                    end
                end
                GET_CLASS: begin
                    sum_a = '0;
                    sum_b = '0;
                    fold(b);
                    got_class = b;
                    phase = GET_ID;
                end
                GET_ID: begin
                    fold(b);
                    got_id = b;
                    phase = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    fold(b);
                    frame_len = {8'h00, b};
                    phase = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    fold(b);
                    frame_len = {b, frame_len[7:0]};
                    bytes_seen = '0;
                    if (frame_len > max_length) begin
                        phase = HUNT_SYNC1;
                        push_event(EV_LEN_REJECT, 8'h00, 16'h0000);
                    end else if (frame_len == 16'h0000) begin
                        phase = GET_CK_A;
                    end else begin
                        phase = GET_PAYLOAD;
                    end
                end
                GET_PAYLOAD: begin
                    fold(b);
                    off = bytes_seen;
                    if ({16'h0000, off} + 32'd1 >= {16'h0000, frame_len}) begin
                        phase = GET_CK_A;
                    end else begin
                        bytes_seen = off + 16'd1;
                    end
                    push_event(EV_PAYLOAD, b, off);
                end
                GET_CK_A: begin
                    rx_sum_a = b;
                    phase = GET_CK_B;
                end
                GET_CK_B: begin
                    phase = HUNT_SYNC1;
                    if (rx_sum_a == sum_a && b == sum_b) begin
                        push_event(EV_FRAME_GOOD, 8'h00, 16'h0000);
                    end else begin
                        push_event(EV_CSUM_ERROR, 8'h00, 16'h0000);
                    end
                end
                default: begin
                    phase = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
                end
            endcase
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        // Compare one output transfer against the oldest pending event.
        function void check_event(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            result_t want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual tuser 0x%0h tdata 0x%0h",
                         $time, tuser, tdata);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", 16'(want.event_kind), 16'(tuser[1:0]));
            compare_field("msg_kind", 16'(want.msg_kind), 16'(tuser[3:2]));
            compare_field("data_byte", 16'(want.data_byte), 16'(tdata[7:0]));
            compare_field("byte_offset", want.byte_offset, tdata[23:8]);
            compare_field("msg_class", 16'(want.msg_class), 16'(tdata[31:24]));
            compare_field("msg_id", 16'(want.msg_id), 16'(tdata[39:32]));
            compare_field("frame_length", want.frame_length, tdata[55:40]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [15:0]           cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    deframe_tracker tracker;
    int             rx_count = 0;
    int             burst_left = 0;
    int             cycle_count = 0;
    logic [15:0]    max_len_setting = DEFAULT_MAX_LENGTH;

    ubx_frame_deframer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Check every output transfer and guard against a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_event(m_tdata, m_tuser);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver pacing, with one long hold-off so the block backs up into its input.
    initial begin : receiver_pace
        rx_pace_t pace;
        int       pace_left;
        int       hold_left;
        bit       hold_done;
        pace = PACE_FULL;
        pace_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && rx_count >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (pace_left == 0) begin
                    pace = rx_pace_t'($urandom_range(0, 3));
                    pace_left = $urandom_range(16, 96);
                end
                pace_left--;
                case (pace)
                    PACE_FULL:     m_tready <= 1'b1;
                    PACE_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                    PACE_PERIODIC: m_tready <= (pace_left % 3 != 0);
                    default:       m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one byte on the input, in bursts with random gaps between them.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        tracker.note_rx_byte(b);
        rx_count++;
    endtask

    // Build a frame with a correct checksum unless a flaw is asked for.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input frame_flaw_t flaw);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] b;
        logic [7:0] head [4];
        int         payload_count;
        ck_a = '0;
        ck_b = '0;
        head = '{cls, id, len[7:0], len[15:8]};
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < 4; i++) begin
            ck_a = ck_a + head[i];
            ck_b = ck_b + ck_a;
            send_byte(head[i]);
        end
        if (len > max_len_setting) begin
            return;
        end
        payload_count = (flaw == FLAW_TRUNCATED && len != 0) ?
                        $urandom_range(0, int'(len) - 1) : int'(len);
        for (int i = 0; i < payload_count; i++) begin
            b = 8'($urandom);
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
            send_byte(b);
        end
        if (flaw == FLAW_TRUNCATED && len != 0) begin
            return;
        end
        if (flaw == FLAW_BAD_CK_A) begin
            ck_a = ck_a ^ 8'($urandom_range(1, 255));
        end
        if (flaw == FLAW_BAD_CK_B) begin
            ck_b = ck_b ^ 8'($urandom_range(1, 255));
        end
        send_byte(ck_a);
        send_byte(ck_b);
    endtask

    // Mostly well-formed frames, with damaged frames, oversize headers and line noise.
    task automatic random_traffic(input int budget);
        int          stop_at;
        int          pick;
        int          cap;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [7:0]  b;
        logic [15:0] len;
        stop_at = rx_count + budget;
        while (rx_count < stop_at) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: begin
                    cls = NAV_CLASS;
                    id = PVT_ID;
                end
                1: begin
                    cls = NAV_CLASS;
                    id = RELPOS_ID;
                end
                2: begin
                    cls = NAV_CLASS;
                    id = 8'($urandom);
                end
                default: begin
                    cls = 8'($urandom);
                    id = 8'($urandom);
                end
            endcase
            cap = (max_len_setting < 16'd12) ? int'(max_len_setting) : 12;
            len = 16'($urandom_range(0, cap));
            if (pick < 60) begin
                send_frame(cls, id, len, FLAW_NONE);
            end else if (pick < 70) begin
                send_frame(cls, id, len, (pick < 65) ? FLAW_BAD_CK_A : FLAW_BAD_CK_B);
            end else if (pick < 78) begin
                if (max_len_setting != 16'hFFFF) begin
                    len = 16'($urandom_range(int'(max_len_setting) + 1, 65535));
                end
                send_frame(cls, id, len, FLAW_NONE);
            end else if (pick < 84) begin
                // A cut-short payload swallows the start of whatever follows.
                send_frame(cls, id, len,
                           (max_len_setting > DEFAULT_MAX_LENGTH) ? FLAW_NONE : FLAW_TRUNCATED);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom);
                    send_byte((b == SYNC_SECOND) ? 8'h00 : b);
                end
            end else begin
                // A run of first sync bytes that never completes.
                repeat ($urandom_range(1, 3)) send_byte(SYNC_FIRST);
                b = 8'($urandom);
                send_byte((b == SYNC_SECOND) ? 8'h00 : b);
            end
        end
    endtask

    // Stop offering bytes and wait until every event has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        max_len_setting = value;
        tracker.max_length = value;
    endtask

    // Main sequence: directed cases, then random traffic under several length limits.
    initial begin
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Stray bytes, including a second sync byte with no first.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        // Repeated first sync bytes ahead of an empty position-velocity-time frame.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame(NAV_CLASS, PVT_ID, 16'd0, FLAW_NONE);
        // First sync byte followed by something else.
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // Relative-position frame with a bad second checksum byte.
        send_frame(NAV_CLASS, RELPOS_ID, 16'd1, FLAW_BAD_CK_B);
        // Largest possible announced length is rejected.
        send_frame(8'hFF, 8'hFF, 16'hFFFF, FLAW_NONE);
        random_traffic(70);
        wait_for_drain();

        write_max_length(16'd0);
        random_traffic(30);
        wait_for_drain();

        // No limit: one payload long enough to carry into the upper length byte.
        write_max_length(16'hFFFF);
        send_frame(NAV_CLASS, PVT_ID, 16'h0101, FLAW_NONE);
        random_traffic(40);
        wait_for_drain();

        write_max_length(16'd5);
        random_traffic(40);
        wait_for_drain();

        write_max_length(16'($urandom_range(1, 40)));
        random_traffic(30);
        wait_for_drain();

        write_max_length(DEFAULT_MAX_LENGTH);
        random_traffic(20);
        wait_for_drain();

        if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
